/* design/tea_pkg.sv */
// Shared types and constants for the TEA block cipher pipeline.
package tea_pkg;

  localparam int unsigned ROUNDS    = 32;
  localparam int unsigned CELLS     = 2 * ROUNDS;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;
  localparam logic [63:0] SUM_PROD = 64'(DELTA) * 64'(ROUNDS);
  localparam logic [WORD_W-1:0] SUM_DEC_INIT = SUM_PROD[WORD_W-1:0];

  localparam logic [CFG_IDX_W-1:0] CFG_KEY0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3 = 2'd3;

  typedef struct packed {
    logic              action;
    logic [WORD_W-1:0] first_word;
    logic [WORD_W-1:0] second_word;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_first;
    logic [WORD_W-1:0] result_second;
  } out_t;

  typedef struct packed {
    logic [WORD_W-1:0] k0;
    logic [WORD_W-1:0] k1;
    logic [WORD_W-1:0] k2;
    logic [WORD_W-1:0] k3;
  } key_t;

  // Data handed from one cell to the next.
  typedef struct packed {
    logic              valid;
    logic              decrypt;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    logic [WORD_W-1:0] sum;
  } stage_t;

endpackage

/* design/tea_cell.sv */
// One half-round cell of the TEA pipeline.
module tea_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            second_half,
  input  tea_pkg::key_t   keys,
  input  tea_pkg::stage_t in_st,
  output tea_pkg::stage_t out_st
);
  import tea_pkg::*;

  logic              update_y;
  logic [WORD_W-1:0] x;
  logic [WORD_W-1:0] tgt;
  logic [WORD_W-1:0] ka;
  logic [WORD_W-1:0] kb;
  logic [WORD_W-1:0] mix;
  logic [WORD_W-1:0] tgt_next;
  logic [WORD_W-1:0] sum_next;
  stage_t            st;

  // Encrypt touches y first, decrypt touches z first.
  assign update_y = ~(second_half ^ in_st.decrypt);
  assign x   = update_y ? in_st.z : in_st.y;
  assign tgt = update_y ? in_st.y : in_st.z;
  assign ka  = update_y ? keys.k0 : keys.k2;
  assign kb  = update_y ? keys.k1 : keys.k3;

  assign mix = ({x[WORD_W-5:0], 4'b0} + ka) ^ (x + in_st.sum)
             ^ ({5'b0, x[WORD_W-1:5]} + kb);

  assign tgt_next = in_st.decrypt ? (tgt - mix) : (tgt + mix);

  // Advance the round sum after the second half only.
  always_comb begin
    if (!second_half) begin
      sum_next = in_st.sum;
    end else if (in_st.decrypt) begin
      sum_next = in_st.sum - DELTA;
    end else begin
      sum_next = in_st.sum + DELTA;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.valid <= 1'b0;
    end else begin
      st.valid <= in_st.valid;
    end
    st.decrypt <= in_st.decrypt;
    st.y       <= update_y ? tgt_next : in_st.y;
    st.z       <= update_y ? in_st.z : tgt_next;
    st.sum     <= sum_next;
  end

  assign out_st = st;

  a_valid_moves: assert property (@(posedge clk) disable iff (rst)
    in_st.valid |=> out_st.valid)
    else $error("cell dropped a transaction");

  a_z_kept: assert property (@(posedge clk) disable iff (rst)
    update_y |=> out_st.z == $past(in_st.z))
    else $error("cell changed the word it should hold");

  a_y_kept: assert property (@(posedge clk) disable iff (rst)
    !update_y |=> out_st.y == $past(in_st.y))
    else $error("cell changed the word it should hold");

endmodule

/* design/tea_block_cipher.sv */
// Top level of the pipelined TEA block cipher.
//
// Usage:
//   Input channel: drive din (action, first_word, second_word) and raise
//   start; a transaction is taken at each clock edge with start high and
//   busy low. busy is high only while rst is held, so one block can be
//   taken every cycle.
//   Output channel: done pulses for one cycle with dout holding the two
//   processed words. The receiver cannot stall; results must be taken on
//   the cycle they appear.
//   Key port: cfg_we, cfg_index (0..3 for key words 0..3) and cfg_data
//   write a key word at the clock edge; change keys only while the
//   pipeline is empty.
// Pipeline: each block walks a row of 2*ROUNDS half-round cells, one cell
//   per cycle, and the throughput is one block per cycle. Each cell holds
//   one add/xor/add half-round, which sets the clock period.
// Reset: clears the key words to zero and every valid bit in the row;
//   blocks in flight are dropped.
module tea_block_cipher (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  tea_pkg::in_t                       din,
  output logic                               done,
  output tea_pkg::out_t                      dout,
  input  logic                               cfg_we,
  input  logic [tea_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tea_pkg::WORD_W-1:0]         cfg_data
);
  import tea_pkg::*;

  key_t   keys;
  stage_t chain [CELLS+1];

  // Key registers; every index of the port maps onto a key word.
  always_ff @(posedge clk) begin
    if (rst) begin
      keys <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY0: keys.k0 <= cfg_data;
        CFG_KEY1: keys.k1 <= cfg_data;
        CFG_KEY2: keys.k2 <= cfg_data;
        CFG_KEY3: keys.k3 <= cfg_data;
        default:  keys.k0 <= keys.k0;
      endcase
    end
  end

  assign busy = rst;

  // Feed the head of the row; the first sum depends on direction.
  assign chain[0].valid   = start & ~busy;
  assign chain[0].decrypt = din.action;
  assign chain[0].y       = din.first_word;
  assign chain[0].z       = din.second_word;
  assign chain[0].sum     = din.action ? SUM_DEC_INIT : DELTA;

  // Even cells run the first half of a round, odd cells the second.
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    tea_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .second_half (1'(i % 2)),
      .keys        (keys),
      .in_st       (chain[i]),
      .out_st      (chain[i+1])
    );
  end

  // The last cell's register is the output register.
  assign done               = chain[CELLS].valid;
  assign dout.result_first  = chain[CELLS].y;
  assign dout.result_second = chain[CELLS].z;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##CELLS done)
    else $error("accepted transaction did not complete on time");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##CELLS !done)
    else $error("result strobe without a matching transaction");

  a_busy_only_in_reset: assert property (@(posedge clk)
    busy == rst)
    else $error("busy raised outside reset");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the tea_block_cipher pipeline.
`timescale 1ns / 100ps

module tb_top;
  import tea_pkg::*;

  // Action codes carried in the input block.
  localparam logic ACT_ENCRYPT = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  // Report only the first few failures in detail; count the rest.
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned PHASE_ITEMS  = 210;
  localparam int unsigned KEY_PHASES   = 7;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       start     = 1'b0;
  logic       busy;
  in_t        din       = '0;
  logic       done;
  out_t       dout;
  logic       cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_KEY0;
  logic [WORD_W-1:0]    cfg_data  = '0;

  // Blocks waiting to be offered, and ciphertexts/plaintexts owed by the dut.
  in_t         pending_blocks[$];
  out_t        owed_blocks[$];
  // Key words as the dut should currently hold them.
  key_t        key_copy = '0;
  int unsigned sender_idle_pct = 0;
  int unsigned fail_count = 0;

  tea_block_cipher dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .din       (din),
    .done      (done),
    .dout      (dout),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // One TEA half-round mix of word x under the running sum and a key pair.
  function automatic logic [WORD_W-1:0] half_round_mix(
    input logic [WORD_W-1:0] x,
    input logic [WORD_W-1:0] sum,
    input logic [WORD_W-1:0] ka,
    input logic [WORD_W-1:0] kb
  );
    half_round_mix = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
  endfunction

  // Full TEA encrypt or decrypt of one block under key k.
  function automatic out_t tea_cipher(input in_t blk, input key_t k);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    logic [WORD_W-1:0] sum;
    out_t              res;
    y = blk.first_word;
    z = blk.second_word;
    if (blk.action == ACT_ENCRYPT) begin
      sum = '0;
      for (int n = 0; n < ROUNDS; n++) begin
        sum = sum + DELTA;
        y = y + half_round_mix(z, sum, k.k0, k.k1);
        z = z + half_round_mix(y, sum, k.k2, k.k3);
      end
    end else begin
      // Decryption starts from the sum that encryption ends with.
      sum = '0;
      for (int n = 0; n < ROUNDS; n++) sum = sum + DELTA;
      for (int n = 0; n < ROUNDS; n++) begin
        z = z - half_round_mix(y, sum, k.k2, k.k3);
        y = y - half_round_mix(z, sum, k.k0, k.k1);
        sum = sum - DELTA;
      end
    end
    res.result_first  = y;
    res.result_second = z;
    return res;
  endfunction

  // Random word, biased toward the extremes now and then.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       pick_word = 32'h0000_0000;
      1:       pick_word = 32'hffff_ffff;
      2:       pick_word = 32'h8000_0000;
      3:       pick_word = 32'h0000_0001;
      default: pick_word = $urandom;
    endcase
  endfunction

  function automatic in_t rand_block();
    in_t blk;
    blk.action      = 1'($urandom_range(0, 1));
    blk.first_word  = pick_word();
    blk.second_word = pick_word();
    return blk;
  endfunction

  function automatic in_t make_block(input logic act, input logic [WORD_W-1:0] w0,
                                     input logic [WORD_W-1:0] w1);
    in_t blk;
    blk.action      = act;
    blk.first_word  = w0;
    blk.second_word = w1;
    return blk;
  endfunction

  // Queue a block and then the opposite action on its predicted output, so
  // the second transaction must give back the original words.
  task automatic queue_round_trip(input in_t blk);
    out_t mid;
    mid = tea_cipher(blk, key_copy);
    pending_blocks.push_back(blk);
    pending_blocks.push_back(make_block(~blk.action, mid.result_first, mid.result_second));
  endtask

  // Write all four key words, one per clock, then drop the write enable.
  task automatic load_keys(input key_t k);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_KEY0;
    cfg_data  <= k.k0;
    @(posedge clk);
    cfg_index <= CFG_KEY1;
    cfg_data  <= k.k1;
    @(posedge clk);
    cfg_index <= CFG_KEY2;
    cfg_data  <= k.k2;
    @(posedge clk);
    cfg_index <= CFG_KEY3;
    cfg_data  <= k.k3;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_data  <= $urandom;
    key_copy = k;
  endtask

  // Hold until every queued block is taken and every owed result is back.
  task automatic drain();
    while (pending_blocks.size() != 0 || start || owed_blocks.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  // Driver: offer queued blocks, idling at random per the current phase.
  // A transaction completes at an edge with start high and busy low; the
  // expected result is computed right there with the keys then in force.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        owed_blocks.push_back(tea_cipher(din, key_copy));
      end
      // Hold the current offer while busy; otherwise pick the next move.
      if (!start || !busy) begin
        if (pending_blocks.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          start <= 1'b1;
          din   <= pending_blocks.pop_front();
        end else begin
          // Idle cycle: scramble din so stale data can never pass as a block.
          start <= 1'b0;
          din   <= rand_block();
        end
      end
    end
  end

  // Monitor: every done pulse must match the oldest owed result.
  always @(posedge clk) begin : result_check
    out_t want;
    if (!rst && done) begin
      if (owed_blocks.size() == 0) begin
        if (fail_count < REPORT_LIMIT) begin
          $display("unexpected result: first %h second %h",
                   dout.result_first, dout.result_second);
        end
        fail_count++;
      end else begin
        want = owed_blocks.pop_front();
        if (dout.result_first !== want.result_first ||
            dout.result_second !== want.result_second) begin
          if (fail_count < REPORT_LIMIT) begin
            $display("mismatch: first exp %h got %h, second exp %h got %h",
                     want.result_first, dout.result_first,
                     want.result_second, dout.result_second);
          end
          fail_count++;
        end
      end
    end
  end

  // Sequencer: reset, directed blocks under the reset key, then random
  // phases, each loading its own key and one of three idle rates in turn.
  initial begin : sequencer
    key_t          phase_key;
    int unsigned   queued;
    int unsigned   idle_rates[3];
    idle_rates = '{0, 63, 34};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part: key still all zero from reset. Cover both actions on
    // the word extremes, then round trips through encrypt and decrypt.
    sender_idle_pct = 0;
    @(negedge clk);
    for (int a = 0; a < 2; a++) begin
      pending_blocks.push_back(make_block(1'(a), 32'h0000_0000, 32'h0000_0000));
      pending_blocks.push_back(make_block(1'(a), 32'hffff_ffff, 32'hffff_ffff));
      pending_blocks.push_back(make_block(1'(a), 32'h8000_0000, 32'h0000_0001));
      pending_blocks.push_back(make_block(1'(a), 32'h0000_0001, 32'h8000_0000));
      pending_blocks.push_back(make_block(1'(a), 32'h0000_0000, 32'hffff_ffff));
      pending_blocks.push_back(make_block(1'(a), 32'hffff_ffff, 32'h0000_0000));
      pending_blocks.push_back(make_block(1'(a), 32'haaaa_aaaa, 32'h5555_5555));
    end
    queue_round_trip(make_block(ACT_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef));
    queue_round_trip(make_block(ACT_DECRYPT, 32'hfedc_ba98, 32'h7654_3210));
    drain();

    for (int p = 0; p < KEY_PHASES; p++) begin
      case (p)
        0:       phase_key = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
        2:       phase_key = '{32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555};
        4:       phase_key = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff};
        6:       phase_key = '0;
        default: phase_key = '{$urandom, $urandom, $urandom, $urandom};
      endcase
      load_keys(phase_key);

      // Fill on the falling edge so the driver never sees a half-built queue.
      @(negedge clk);
      sender_idle_pct = idle_rates[p % 3];
      queued = 0;
      while (queued < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0) begin
          queue_round_trip(rand_block());
          queued += 2;
        end else begin
          pending_blocks.push_back(rand_block());
          queued += 1;
        end
      end
      drain();
    end

    // Let the row of cells empty out and catch any stray done pulse.
    repeat (CELLS + 16) @(posedge clk);
    if (fail_count == 0 && owed_blocks.size() == 0) begin
      $display("tea_block_cipher verification clean");
    end else begin
      $display("tea_block_cipher verification failed");
    end
    $finish;
  end

  // Watchdog: end a hung run.
  initial begin
    #2_000_000;
    $display("tea_block_cipher verification failed");
    $finish;
  end

endmodule

/* tea_block_cipher.f */
design/tea_pkg.sv
design/tea_cell.sv
design/tea_block_cipher.sv
tb/sv/tb_top.sv
